[sv/rtr_pkg.sv]
`timescale 1ns / 1ps

package rtr_pkg;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_STOP   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_NO_STEP = 2'd2;

    localparam logic CFG_RING_LENGTH    = 1'b0;
    localparam logic CFG_STEPS_PER_TICK = 1'b1;

    localparam logic [14:0] RING_LENGTH_RESET    = 15'd16384;
    localparam logic [31:0] STEPS_PER_TICK_RESET = 32'd42950;

    localparam logic signed [31:0] ONE_UNIT = 32'sh0001_0000;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] sample_value;
        logic [63:0]        timestamp;
        logic [13:0]        read_index;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic signed [31:0] range_high;
        logic signed [31:0] range_low;
        logic [13:0]        write_index;
        logic               wrapped;
    } out_t;

    // queued word plus what the front has already worked out about it
    typedef struct packed {
        in_t  word;
        logic read_ok;
    } qent_t;

endpackage

[sv/rtr_front.sv]
`timescale 1ns / 1ps

module rtr_front #(
    parameter int RING_DEPTH = 16384
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  rtr_pkg::in_t  cmd_word,
    output logic          q_valid,
    output rtr_pkg::qent_t q_data,
    input  logic          q_pop
);
    import rtr_pkg::*;

    qent_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    qent_t       classified;

    assign cmd_stall = (count_reg == 2'd2);
    assign push      = cmd_valid && !cmd_stall;
    assign q_valid   = (count_reg != 2'd0);
    assign q_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        classified.word    = cmd_word;
        classified.read_ok = (32'(cmd_word.read_index) < 32'(RING_DEPTH));
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

[sv/rtr_div.sv]
`timescale 1ns / 1ps

module rtr_div #(
    parameter int NW = 33,
    parameter int DW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic                 busy,
    output logic signed [NW:0]   quo
);
    localparam int CW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            neg_reg, neg_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [NW-1:0]   dvd_reg, dvd_next;
    logic [DW:0]     rem_reg, rem_next;
    logic [DW:0]     rem_sh;
    logic            ge;

    assign busy = busy_reg;
    assign quo  = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});

    always_comb
    begin
        rem_sh    = {rem_reg[DW-1:0], dvd_reg[NW-1]};
        ge        = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        den_next  = den_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            neg_next  = num[NW-1];
            den_next  = den;
            dvd_next  = num[NW-1] ? NW'(-num) : NW'(num);
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, restoring
            rem_next = ge ? rem_sh - {1'b0, den_reg} : rem_sh;
            dvd_next = {dvd_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        den_reg <= den_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

endmodule

[sv/rtr_back.sv]
`timescale 1ns / 1ps

module rtr_back #(
    parameter int              RING_DEPTH     = 16384,
    parameter longint unsigned MAX_FILL_STEPS = 65535
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  rtr_pkg::qent_t q_data,
    output logic           q_pop,
    input  logic [14:0]    ring_length,
    input  logic [31:0]    steps_per_tick,
    output logic           res_valid,
    input  logic           res_stall,
    output rtr_pkg::out_t  res_word
);
    import rtr_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_MUL_HI = 4'd3;
    localparam logic [3:0] S_MUL_LO = 4'd4;
    localparam logic [3:0] S_SUM    = 4'd5;
    localparam logic [3:0] S_DIV_GO = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_FILL   = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic                clr_reply_reg, clr_reply_next;
    qent_t               item_reg, item_next;
    logic [AW-1:0]       newest_reg, newest_next;
    logic                running_reg, running_next;
    logic                primed_reg, primed_next;
    logic [63:0]         last_ts_reg, last_ts_next;
    logic signed [31:0]  last_wr_reg, last_wr_next;
    logic signed [31:0]  shown_hi_reg, shown_hi_next;
    logic signed [31:0]  shown_lo_reg, shown_lo_next;
    logic signed [31:0]  pass_hi_reg, pass_hi_next;
    logic signed [31:0]  pass_lo_reg, pass_lo_next;
    logic [63:0]         delta_reg, delta_next;
    logic [63:0]         prod_hi_reg, prod_hi_next;
    logic [63:0]         prod_lo_reg, prod_lo_next;
    logic [31:0]         steps_reg, steps_next;
    logic [31:0]         remain_reg, remain_next;
    logic signed [34:0]  acc_reg, acc_next;
    logic                wrap_reg, wrap_next;
    logic                res_valid_reg, res_valid_next;
    out_t                res_reg, res_next;

    logic [31:0]         ring_mem [RING_DEPTH];
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [31:0]         mem_wdata;
    logic                mem_re;
    logic [31:0]         rd_data_reg;

    logic                div_start;
    logic                div_busy;
    logic signed [32:0]  div_num;
    logic signed [33:0]  div_quo;

    logic [31:0]         len_eff;
    logic                adv_wrap;
    logic [AW-1:0]       adv_slot;
    logic signed [34:0]  acc_sum;
    logic [63:0]         step_sum;
    logic signed [31:0]  v;
    logic signed [31:0]  v_hi;
    logic signed [31:0]  v_lo;
    logic                finish;
    logic [1:0]          fin_status;
    logic signed [31:0]  fin_read;
    logic                fin_wrap;
    logic                w;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        logic signed [31:0] r;
        if (x > 35'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (x < -35'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    rtr_div #(.NW(33), .DW(32)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (steps_reg),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;
    assign v         = item_reg.word.sample_value;
    assign v_hi      = sat32(35'(v) + 35'(ONE_UNIT));
    assign v_lo      = sat32(35'(v) - 35'(ONE_UNIT));
    assign div_num   = 33'(v) - 33'(last_wr_reg);
    assign acc_sum   = acc_reg + 35'(div_quo);
    assign step_sum  = prod_hi_reg + {32'd0, prod_lo_reg[63:32]};

    always_comb
    begin
        if (ring_length == 15'd0)
        begin
            len_eff = 32'd1;
        end
        else if (32'(ring_length) > 32'(RING_DEPTH))
        begin
            len_eff = 32'(RING_DEPTH);
        end
        else
        begin
            len_eff = 32'(ring_length);
        end
        adv_wrap = (32'(newest_reg) + 32'd1 >= len_eff);
        adv_slot = adv_wrap ? '0 : newest_reg + 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_reply_next = clr_reply_reg;
        item_next      = item_reg;
        newest_next    = newest_reg;
        running_next   = running_reg;
        primed_next    = primed_reg;
        last_ts_next   = last_ts_reg;
        last_wr_next   = last_wr_reg;
        shown_hi_next  = shown_hi_reg;
        shown_lo_next  = shown_lo_reg;
        pass_hi_next   = pass_hi_reg;
        pass_lo_next   = pass_lo_reg;
        delta_next     = delta_reg;
        prod_hi_next   = prod_hi_reg;
        prod_lo_next   = prod_lo_reg;
        steps_next     = steps_reg;
        remain_next    = remain_reg;
        acc_next       = acc_reg;
        wrap_next      = wrap_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        div_start      = 1'b0;
        finish         = 1'b0;
        fin_status     = ST_DONE;
        fin_read       = '0;
        fin_wrap       = 1'b0;
        w              = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(RING_DEPTH - 1))
                begin
                    state_next     = S_IDLE;
                    clr_reply_next = 1'b0;
                    finish         = clr_reply_reg;
                end
            end
            S_IDLE:
            begin
                if (q_valid && !res_valid_reg)
                begin
                    q_pop     = 1'b1;
                    item_next = q_data;
                    case (q_data.word.command)
                        CMD_START:
                        begin
                            newest_next    = '0;
                            last_wr_next   = '0;
                            primed_next    = 1'b0;
                            running_next   = 1'b1;
                            clr_addr_next  = '0;
                            clr_reply_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        CMD_STOP:
                        begin
                            running_next = 1'b0;
                            finish       = 1'b1;
                        end
                        CMD_SAMPLE:
                        begin
                            if (!running_reg)
                            begin
                                finish     = 1'b1;
                                fin_status = ST_IGNORED;
                            end
                            else
                            begin
                                delta_next = q_data.word.timestamp - last_ts_reg;
                                state_next = S_MUL_HI;
                            end
                        end
                        default:
                        begin
                            mem_re     = 1'b1;
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                finish   = 1'b1;
                fin_read = item_reg.read_ok ? rd_data_reg : '0;
                state_next = S_IDLE;
            end
            S_MUL_HI:
            begin
                if (!primed_reg)
                begin
                    // first sample after start: seed slot 0 and both range pairs
                    mem_we        = 1'b1;
                    mem_waddr     = '0;
                    mem_wdata     = v;
                    newest_next   = '0;
                    last_wr_next  = v;
                    shown_hi_next = v_hi;
                    shown_lo_next = v_lo;
                    pass_hi_next  = v_hi;
                    pass_lo_next  = v_lo;
                    last_ts_next  = item_reg.word.timestamp;
                    primed_next   = 1'b1;
                    finish        = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    prod_hi_next = 64'(delta_reg[63:32]) * 64'(steps_per_tick);
                    state_next   = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                prod_lo_next = 64'(delta_reg[31:0]) * 64'(steps_per_tick);
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                steps_next = (step_sum > 64'(MAX_FILL_STEPS)) ? 32'(MAX_FILL_STEPS)
                                                               : step_sum[31:0];
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                if (steps_reg == 32'd0)
                begin
                    finish     = 1'b1;
                    fin_status = ST_NO_STEP;
                    state_next = S_IDLE;
                end
                else
                begin
                    div_start   = 1'b1;
                    acc_next    = 35'(last_wr_reg);
                    remain_next = steps_reg - 32'd1;
                    wrap_next   = 1'b0;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                mem_we      = 1'b1;
                mem_waddr   = adv_slot;
                newest_next = adv_slot;
                if (remain_reg != 32'd0)
                begin
                    // ramp slot
                    acc_next    = acc_sum;
                    mem_wdata   = sat32(acc_sum);
                    remain_next = remain_reg - 32'd1;
                    wrap_next   = wrap_reg || adv_wrap;
                end
                else
                begin
                    // exact sample closes the fill
                    w            = wrap_reg || adv_wrap;
                    mem_wdata    = v;
                    last_wr_next = v;
                    last_ts_next = item_reg.word.timestamp;
                    if (w)
                    begin
                        shown_hi_next = pass_hi_reg;
                        shown_lo_next = pass_lo_reg;
                        pass_hi_next  = v_hi;
                        pass_lo_next  = v_lo;
                    end
                    else
                    begin
                        pass_hi_next  = (v > pass_hi_reg) ? v : pass_hi_reg;
                        pass_lo_next  = (v < pass_lo_reg) ? v : pass_lo_reg;
                        shown_hi_next = (v > shown_hi_reg) ? v : shown_hi_reg;
                        shown_lo_next = (v < shown_lo_reg) ? v : shown_lo_reg;
                    end
                    fin_wrap   = w;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            res_valid_next       = 1'b1;
            res_next.status      = fin_status;
            res_next.read_value  = fin_read;
            res_next.range_high  = shown_hi_next;
            res_next.range_low   = shown_lo_next;
            res_next.write_index = 14'(newest_next);
            res_next.wrapped     = fin_wrap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            clr_reply_reg <= 1'b0;
            newest_reg    <= '0;
            running_reg   <= 1'b0;
            primed_reg    <= 1'b0;
            last_ts_reg   <= '0;
            last_wr_reg   <= '0;
            shown_hi_reg  <= '0;
            shown_lo_reg  <= '0;
            pass_hi_reg   <= '0;
            pass_lo_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_reply_reg <= clr_reply_next;
            newest_reg    <= newest_next;
            running_reg   <= running_next;
            primed_reg    <= primed_next;
            last_ts_reg   <= last_ts_next;
            last_wr_reg   <= last_wr_next;
            shown_hi_reg  <= shown_hi_next;
            shown_lo_reg  <= shown_lo_next;
            pass_hi_reg   <= pass_hi_next;
            pass_lo_reg   <= pass_lo_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        delta_reg   <= delta_next;
        prod_hi_reg <= prod_hi_next;
        prod_lo_reg <= prod_lo_next;
        steps_reg   <= steps_next;
        remain_reg  <= remain_next;
        acc_reg     <= acc_next;
        wrap_reg    <= wrap_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[AW'(q_data.word.read_index)];
        end
    end

endmodule

[sv/resampling_trace_ring.sv]
`timescale 1ns / 1ps
// channel   signals                          direction  word
// command   cmd_valid, cmd_stall, cmd_word   in         rtr_pkg::in_t
// result    res_valid, res_stall, res_word   out        rtr_pkg::out_t
// config    cfg_write, cfg_index, cfg_data   in         ring_length, steps_per_tick
//
// A filling sample waits on the divider, then makes one ring write per slot.
// Start sweeps the ring before it replies; after reset the same sweep runs and
// commands queue meanwhile. A two-word queue takes commands while a result
// waits on res_stall.

module resampling_trace_ring #(
    parameter int              RING_DEPTH     = 16384,
    parameter longint unsigned MAX_FILL_STEPS = 65535
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  rtr_pkg::in_t  cmd_word,
    output logic          res_valid,
    input  logic          res_stall,
    output rtr_pkg::out_t res_word,
    input  logic          cfg_write,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data
);
    import rtr_pkg::*;

    logic [14:0] ring_length_reg;
    logic [31:0] spt_reg;
    logic        q_valid;
    qent_t       q_data;
    logic        q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_length_reg <= RING_LENGTH_RESET;
            spt_reg         <= STEPS_PER_TICK_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RING_LENGTH:    ring_length_reg <= cfg_data[14:0];
                CFG_STEPS_PER_TICK: spt_reg         <= cfg_data;
                default:            spt_reg         <= spt_reg;
            endcase
        end
    end

    rtr_front #(.RING_DEPTH(RING_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop)
    );

    rtr_back #(
        .RING_DEPTH     (RING_DEPTH),
        .MAX_FILL_STEPS (MAX_FILL_STEPS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .ring_length    (ring_length_reg),
        .steps_per_tick (spt_reg),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_word       (res_word)
    );

`ifndef NO_ASSERTIONS
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_word.range_low <= res_word.range_high)
        else $error("range_low above range_high");

    a_wrap_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.wrapped |-> res_word.status == ST_DONE)
        else $error("wrap flagged on a sample that did not fill");

    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && !res_valid)
        else $error("queue popped while empty or result pending");
`endif

endmodule
